/* rtl/fdtp_pkg.sv */
// Package holding the token codes, element kinds, phases and shared types of the structure parser.
package fdtp_pkg;

    localparam int MAX_DEPTH_DEFAULT = 64;
    localparam int NUM_LANES = 4;

    localparam logic [31:0] TOKEN_BEGIN_NODE = 32'h0000_0001;
    localparam logic [31:0] TOKEN_END_NODE   = 32'h0000_0002;
    localparam logic [31:0] TOKEN_PROP       = 32'h0000_0003;
    localparam logic [31:0] TOKEN_NOP        = 32'h0000_0004;
    localparam logic [31:0] TOKEN_END        = 32'h0000_0009;

    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;

    typedef enum logic [3:0] {
        KIND_BEGIN    = 4'd0,
        KIND_NAME     = 4'd1,
        KIND_END_NODE = 4'd2,
        KIND_PROP     = 4'd3,
        KIND_LENGTH   = 4'd4,
        KIND_NAME_OFF = 4'd5,
        KIND_DATA     = 4'd6,
        KIND_NOP      = 4'd7,
        KIND_END      = 4'd8,
        KIND_INVALID  = 4'd9,
        KIND_IGNORED  = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_NAME,
        PH_LEN,
        PH_NAMEOFF,
        PH_DATA,
        PH_DONE,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        PTYPE_NIL    = 2'd0,
        PTYPE_STRING = 2'd1,
        PTYPE_U32    = 2'd2,
        PTYPE_BYTES  = 2'd3
    } ptype_t;

    typedef struct packed {
        logic is_zero;
        logic printable;
        logic bad;
    } lane_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] payload;
        logic [2:0]  valid_bytes;
        logic [6:0]  depth;
        logic        name_end;
        ptype_t      prop_type;
        logic        prop_type_valid;
        logic        depth_error;
        logic        truncated;
    } result_t;

endpackage

/* rtl/fdtp_byte_lane.sv */
// One byte lane: classifies a single byte of the word as zero, printable or otherwise.
module fdtp_byte_lane (
    input  logic          [7:0] byte_val,
    input  logic                count_en,
    output fdtp_pkg::lane_t     lane
);
    import fdtp_pkg::*;

    logic is_print;

    assign is_print       = (byte_val >= PRINT_LOW) && (byte_val <= PRINT_HIGH);
    assign lane.is_zero   = (byte_val == 8'h00);
    assign lane.printable = count_en && is_print;
    assign lane.bad       = count_en && !is_print && (byte_val != 8'h00);

endmodule

/* rtl/fdtp_ctrl.sv */
// Token sequencer: holds the parse state, runs the byte lanes and merges their findings into a result.
module fdtp_ctrl #(
    parameter int MAX_DEPTH = fdtp_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic       [31:0] word,
    input  logic              last_word,
    output fdtp_pkg::result_t result
);
    import fdtp_pkg::*;

    localparam logic [6:0] MaxDepth7 = 7'(MAX_DEPTH);

    phase_t      phase_reg, phase_next;
    logic [6:0]  nesting_reg, nesting_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] value_length_reg, value_length_next;
    logic        saw_print_reg, saw_print_next;
    logic        saw_bad_reg, saw_bad_next;
    logic        first_zero_reg, first_zero_next;

    lane_t       lanes [NUM_LANES];
    logic [NUM_LANES-1:0] lane_en;
    logic        full_word;
    logic [2:0]  data_count;
    logic [1:0]  last_idx;
    logic        any_print;
    logic        any_bad;
    logic        fz_upd;
    logic        sp_upd;
    logic        sb_upd;
    logic        open_after;

    assign full_word  = (bytes_left_reg > 32'd4);
    assign data_count = full_word ? 3'd4 : bytes_left_reg[2:0];
    assign last_idx   = 2'(data_count - 3'd1);

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            assign lane_en[g] = full_word || (3'(g + 1) < data_count);
            fdtp_byte_lane u_lane (
                .byte_val (word[31 - 8*g -: 8]),
                .count_en (lane_en[g]),
                .lane     (lanes[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_print = 1'b0;
        any_bad   = 1'b0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            any_print = any_print | lanes[i].printable;
            any_bad   = any_bad | lanes[i].bad;
        end
    end

    assign fz_upd = first_zero_reg
                    | ((bytes_left_reg == value_length_reg) && lanes[0].is_zero);
    assign sp_upd = saw_print_reg | any_print;
    assign sb_upd = saw_bad_reg | any_bad;

    always_comb
    begin
        phase_next        = phase_reg;
        nesting_next      = nesting_reg;
        bytes_left_next   = bytes_left_reg;
        value_length_next = value_length_reg;
        saw_print_next    = saw_print_reg;
        saw_bad_next      = saw_bad_reg;
        first_zero_next   = first_zero_reg;
        open_after        = 1'b0;

        result                 = '0;
        result.kind            = KIND_IGNORED;
        result.payload         = word;
        result.valid_bytes     = 3'd4;
        result.prop_type       = PTYPE_NIL;

        unique case (phase_reg)
            PH_TOKEN:
            begin
                unique case (word)
                    TOKEN_BEGIN_NODE:
                    begin
                        result.kind = KIND_BEGIN;
                        if (nesting_reg >= MaxDepth7)
                        begin
                            nesting_next       = MaxDepth7;
                            result.depth_error = 1'b1;
                        end
                        else
                        begin
                            nesting_next = nesting_reg + 7'd1;
                        end
                        phase_next = PH_NAME;
                        open_after = 1'b1;
                    end
                    TOKEN_END_NODE:
                    begin
                        result.kind = KIND_END_NODE;
                        if (nesting_reg == 7'd0)
                            result.depth_error = 1'b1;
                        else
                            nesting_next = nesting_reg - 7'd1;
                    end
                    TOKEN_PROP:
                    begin
                        result.kind = KIND_PROP;
                        phase_next  = PH_LEN;
                        open_after  = 1'b1;
                    end
                    TOKEN_NOP:
                    begin
                        result.kind = KIND_NOP;
                    end
                    TOKEN_END:
                    begin
                        result.kind = KIND_END;
                        phase_next  = PH_DONE;
                    end
                    default:
                    begin
                        result.kind = KIND_INVALID;
                        phase_next  = PH_STOP;
                    end
                endcase
            end
            PH_NAME:
            begin
                result.kind = KIND_NAME;
                for (int i = NUM_LANES - 1; i >= 0; i--)
                begin
                    if (lanes[i].is_zero)
                    begin
                        result.valid_bytes = 3'(i);
                        result.name_end    = 1'b1;
                    end
                end
                if (result.name_end)
                    phase_next = PH_TOKEN;
                else
                    open_after = 1'b1;
            end
            PH_LEN:
            begin
                result.kind       = KIND_LENGTH;
                value_length_next = word;
                bytes_left_next   = word;
                saw_print_next    = 1'b0;
                saw_bad_next      = 1'b0;
                first_zero_next   = 1'b0;
                phase_next        = PH_NAMEOFF;
                open_after        = 1'b1;
            end
            PH_NAMEOFF:
            begin
                result.kind = KIND_NAME_OFF;
                if (value_length_reg == 32'd0)
                begin
                    result.prop_type_valid = 1'b1;
                    result.prop_type       = PTYPE_NIL;
                    phase_next             = PH_TOKEN;
                end
                else
                begin
                    phase_next = PH_DATA;
                    open_after = 1'b1;
                end
            end
            PH_DATA:
            begin
                result.kind        = KIND_DATA;
                result.valid_bytes = data_count;
                first_zero_next    = fz_upd;
                saw_print_next     = sp_upd;
                saw_bad_next       = sb_upd;
                if (full_word)
                begin
                    bytes_left_next = bytes_left_reg - 32'd4;
                    open_after      = 1'b1;
                end
                else
                begin
                    result.prop_type_valid = 1'b1;
                    if ((value_length_reg == 32'd0)
                        || ((value_length_reg == 32'd1) && fz_upd))
                        result.prop_type = PTYPE_NIL;
                    else if (lanes[last_idx].is_zero && !sb_upd && sp_upd)
                        result.prop_type = PTYPE_STRING;
                    else if (value_length_reg[1:0] == 2'd0)
                        result.prop_type = PTYPE_U32;
                    else
                        result.prop_type = PTYPE_BYTES;
                    bytes_left_next = 32'd0;
                    phase_next      = PH_TOKEN;
                end
            end
            PH_DONE:
            begin
                result.valid_bytes = 3'd0;
            end
            default:
            begin
                result.valid_bytes = 3'd0;
                phase_next         = PH_STOP;
            end
        endcase

        result.depth = nesting_next;

        if (last_word && (phase_next != PH_STOP))
        begin
            result.truncated  = open_after;
            phase_next        = PH_TOKEN;
            nesting_next      = 7'd0;
            bytes_left_next   = 32'd0;
            value_length_next = 32'd0;
            saw_print_next    = 1'b0;
            saw_bad_next      = 1'b0;
            first_zero_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TOKEN;
            nesting_reg      <= 7'd0;
            bytes_left_reg   <= 32'd0;
            value_length_reg <= 32'd0;
            saw_print_reg    <= 1'b0;
            saw_bad_reg      <= 1'b0;
            first_zero_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            nesting_reg      <= nesting_next;
            bytes_left_reg   <= bytes_left_next;
            value_length_reg <= value_length_next;
            saw_print_reg    <= saw_print_next;
            saw_bad_reg      <= saw_bad_next;
            first_zero_reg   <= first_zero_next;
        end
    end

endmodule

/* rtl/fdt_structure_token_parser.sv */
// Top level of the devicetree structure-block token parser with its output skid buffer.
//
// Usage: the structure block enters one 32-bit word per request on the word channel
// (word, last_word, word_valid, word_ready). Each word yields exactly one result request
// on the result channel (element_kind, payload, valid_bytes, depth, name_end, prop_type,
// prop_type_valid, depth_error, truncated, result_valid, result_ready).
// Each result is registered in the output register, or in the skid register on a stall.
// Throughput is one word per cycle while word_ready is high; four byte lanes inspect the
// bytes of a word together and the sequencer merges their findings in the same cycle.
// An output register backed by a one-entry skid register separates the channels, so a new
// word is taken while a result waits; word_ready falls only when both are full.
// When the receiver stalls, results are held in order and none is dropped.
// Reset clears the parse state (expect a token, depth zero) and empties both registers.
// A word flagged last_word ends the block and returns the parser to its reset state,
// except after an invalid token, which stops the parser until the next reset.
module fdt_structure_token_parser #(
    parameter int MAX_DEPTH = fdtp_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_ready,
    input  logic [31:0] word,
    input  logic        last_word,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  element_kind,
    output logic [31:0] payload,
    output logic [2:0]  valid_bytes,
    output logic [6:0]  depth,
    output logic        name_end,
    output logic [1:0]  prop_type,
    output logic        prop_type_valid,
    output logic        depth_error,
    output logic        truncated
);
    import fdtp_pkg::*;

    logic    accept;
    result_t new_result;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign word_ready = !skid_valid_reg;
    assign accept     = word_valid && word_ready;

    fdtp_ctrl #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (word),
        .last_word (last_word),
        .result    (new_result)
    );

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (accept)
        begin
            if (main_valid_reg && !result_ready)
            begin
                skid_next       = new_result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next       = new_result;
                main_valid_next = 1'b1;
            end
        end
        else if (main_valid_reg && result_ready)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign result_valid    = main_valid_reg;
    assign element_kind    = main_reg.kind;
    assign payload         = main_reg.payload;
    assign valid_bytes     = main_reg.valid_bytes;
    assign depth           = main_reg.depth;
    assign name_end        = main_reg.name_end;
    assign prop_type       = main_reg.prop_type;
    assign prop_type_valid = main_reg.prop_type_valid;
    assign depth_error     = main_reg.depth_error;
    assign truncated       = main_reg.truncated;

endmodule
